// ===== rtl/core/dcmt_pkg.sv =====
// Shared types, constants and widths of the detection cluster merge table.
package dcmt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned COORD_BITS_DEF  = 12;

  localparam int unsigned SIZE_W  = 10;
  localparam int unsigned HITS_W  = 16;
  localparam int unsigned MIDX_W  = 4;
  localparam int unsigned OCNT_W  = 5;
  localparam int unsigned OUT_W   = 1 + MIDX_W + 1 + OCNT_W + OCNT_W;

  // Scaled size is (size << 8) / 7, at most 18 bits wide.
  localparam int unsigned SSZ_W       = SIZE_W + 8;
  // Reciprocal of 7 as ceil(2^21 / 7); exact for every 18-bit dividend.
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP7 = RECIP_W'(299594);

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } dcmt_state_e;

  typedef struct packed {
    logic start;       // latch the accepted item and clear the scan state
    logic scan_issue;  // read the next table entry
    logic finish;      // write back, update counts and load the result
  } dcmt_cmd_t;

  typedef struct packed {
    logic scan_done;   // every valid entry has been read
    logic pipe_busy;   // reads still in the compare pipeline
    logic out_free;    // result register can take a new result
  } dcmt_status_t;

endpackage

// ===== rtl/core/dcmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dcmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dcmt_ctrl.sv =====
// Sequencing state machine: accept, scan, drain, write back.
module dcmt_ctrl
  import dcmt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dcmt_status_t status_i,
  output dcmt_cmd_t    cmd_o
);

  dcmt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.start      = 1'b0;
    cmd_o.scan_issue = 1'b0;
    cmd_o.finish     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // The result register must be free before the table is touched.
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dcmt_dpath.sv =====
// Table datapath: entry RAM, compare pipeline, merge arithmetic and result register.
module dcmt_dpath
  import dcmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dcmt_cmd_t             cmd_i,
  output dcmt_status_t          status_o,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  input  logic [SIZE_W-1:0]     pattern_size_i,
  input  logic [HITS_W-1:0]     initial_hits_i,
  input  logic                  cfg_we_i,
  input  logic [HITS_W-1:0]     cfg_min_hits_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  merged_o,
  output logic [MIDX_W-1:0]     merged_index_o,
  output logic                  dropped_o,
  output logic [OCNT_W-1:0]     entry_count_o,
  output logic [OCNT_W-1:0]     confident_count_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = 2 * COORD_BITS + SIZE_W + HITS_W;
  localparam int unsigned DSH_W = COORD_BITS + 8;
  localparam int unsigned CMP_W = (DSH_W > SSZ_W) ? DSH_W : SSZ_W;
  localparam int unsigned PRD_W = RECIP_SHIFT + SSZ_W;

  function automatic logic [SSZ_W-1:0] scale_size(input logic [SIZE_W-1:0] s);
    logic [PRD_W-1:0] prod;
    prod = PRD_W'({s, 8'b0}) * PRD_W'(RECIP7);
    return prod[RECIP_SHIFT +: SSZ_W];
  endfunction

  // Configuration and table occupancy.
  logic [HITS_W-1:0] min_hits_q;
  logic [CNT_W-1:0]  count_q;

  // Latched item.
  logic [COORD_BITS-1:0] in_x_q, in_y_q;
  logic [SIZE_W-1:0]     in_size_q;
  logic [HITS_W-1:0]     in_hits_q;
  logic [SSZ_W-1:0]      in_ssz_q;

  // Scan address and compare pipeline.
  logic [CNT_W-1:0]      rd_idx_q;
  logic                  p1_v_q;
  logic [IDX_W-1:0]      p1_idx_q;
  logic [ENT_W-1:0]      rdata;
  logic                  p2_v_q;
  logic [IDX_W-1:0]      p2_idx_q;
  logic [COORD_BITS-1:0] p2_x_q, p2_y_q;
  logic [SIZE_W-1:0]     p2_size_q;
  logic [HITS_W-1:0]     p2_hits_q;
  logic [SSZ_W-1:0]      p2_ssz_q;

  // First match and running confident count.
  logic                  m_found_q;
  logic [IDX_W-1:0]      m_idx_q;
  logic [COORD_BITS-1:0] m_x_q, m_y_q;
  logic [SIZE_W-1:0]     m_size_q;
  logic [HITS_W-1:0]     m_hits_q;
  logic [CNT_W-1:0]      conf_q;

  // Result register.
  logic                  out_valid_q;
  logic                  out_merged_q, out_dropped_q;
  logic [MIDX_W-1:0]     out_midx_q;
  logic [OCNT_W-1:0]     out_cnt_q, out_conf_q;

  // Compare stage.
  logic [COORD_BITS-1:0] dx, dy;
  logic [SSZ_W-1:0]      dsz;
  logic                  hit, take;

  // Write-back.
  logic                  append, we;
  logic [IDX_W-1:0]      waddr;
  logic [ENT_W-1:0]      wdata;
  logic [COORD_BITS:0]   sum_x, sum_y;
  logic [SIZE_W:0]       sum_size;
  logic [HITS_W-1:0]     new_hits;
  logic                  conf_inc;
  logic [CNT_W-1:0]      conf_next, count_next;

  dcmt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan_issue),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign status_o.scan_done = (rd_idx_q == count_q);
  assign status_o.pipe_busy = p1_v_q | p2_v_q;
  assign status_o.out_free  = !out_valid_q | out_ready_i;

  // Entry layout in the RAM, lowest bits first: x, y, size, hits.
  always_comb begin
    dx  = (in_x_q > p2_x_q) ? in_x_q - p2_x_q : p2_x_q - in_x_q;
    dy  = (in_y_q > p2_y_q) ? in_y_q - p2_y_q : p2_y_q - in_y_q;
    dsz = (in_ssz_q > p2_ssz_q) ? in_ssz_q - p2_ssz_q : p2_ssz_q - in_ssz_q;
    hit = (CMP_W'({dx, 8'b0}) < CMP_W'(p2_ssz_q)) &&
          (CMP_W'({dy, 8'b0}) < CMP_W'(p2_ssz_q)) &&
          (dsz < (p2_ssz_q >> 2));
    take = p2_v_q && hit && !m_found_q;
  end

  always_comb begin
    append   = !m_found_q && (count_q < CNT_W'(TABLE_DEPTH));
    we       = cmd_i.finish && (m_found_q || append);
    waddr    = m_found_q ? m_idx_q : count_q[IDX_W-1:0];
    sum_x    = {1'b0, m_x_q} + {1'b0, in_x_q};
    sum_y    = {1'b0, m_y_q} + {1'b0, in_y_q};
    sum_size = {1'b0, m_size_q} + {1'b0, in_size_q};
    new_hits = (m_hits_q == HITS_MAX) ? m_hits_q : m_hits_q + 1'b1;
    if (m_found_q) begin
      wdata    = {new_hits, sum_size[SIZE_W:1], sum_y[COORD_BITS:1], sum_x[COORD_BITS:1]};
      // Only the merged entry changes; it may cross the threshold now.
      conf_inc = (m_hits_q <= min_hits_q) && (new_hits > min_hits_q);
    end else begin
      wdata    = {in_hits_q, in_size_q, in_y_q, in_x_q};
      conf_inc = append && (in_hits_q > min_hits_q);
    end
    conf_next  = conf_q + CNT_W'(conf_inc);
    count_next = count_q + CNT_W'(append);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hits_q  <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      m_found_q   <= 1'b0;
      conf_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_hits_q <= cfg_min_hits_i;
      end
      p1_v_q <= cmd_i.scan_issue;
      p2_v_q <= p1_v_q;
      if (cmd_i.start) begin
        rd_idx_q  <= '0;
        m_found_q <= 1'b0;
        conf_q    <= '0;
      end else begin
        if (cmd_i.scan_issue) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
        if (take) begin
          m_found_q <= 1'b1;
        end
        if (p2_v_q && (p2_hits_q > min_hits_q)) begin
          conf_q <= conf_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q     <= count_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      in_x_q    <= x_coord_i;
      in_y_q    <= y_coord_i;
      in_size_q <= pattern_size_i;
      in_hits_q <= initial_hits_i;
      in_ssz_q  <= scale_size(pattern_size_i);
    end
    p1_idx_q  <= rd_idx_q[IDX_W-1:0];
    p2_idx_q  <= p1_idx_q;
    p2_x_q    <= rdata[COORD_BITS-1:0];
    p2_y_q    <= rdata[2*COORD_BITS-1:COORD_BITS];
    p2_size_q <= rdata[2*COORD_BITS+SIZE_W-1:2*COORD_BITS];
    p2_hits_q <= rdata[ENT_W-1:2*COORD_BITS+SIZE_W];
    p2_ssz_q  <= scale_size(rdata[2*COORD_BITS+SIZE_W-1:2*COORD_BITS]);
    if (take) begin
      m_idx_q  <= p2_idx_q;
      m_x_q    <= p2_x_q;
      m_y_q    <= p2_y_q;
      m_size_q <= p2_size_q;
      m_hits_q <= p2_hits_q;
    end
    if (cmd_i.finish) begin
      out_merged_q  <= m_found_q;
      out_midx_q    <= m_found_q ? MIDX_W'(m_idx_q) : '0;
      out_dropped_q <= !m_found_q && !append;
      out_cnt_q     <= OCNT_W'(count_next);
      out_conf_q    <= OCNT_W'(conf_next);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign merged_o          = out_merged_q;
  assign merged_index_o    = out_midx_q;
  assign dropped_o         = out_dropped_q;
  assign entry_count_o     = out_cnt_q;
  assign confident_count_o = out_conf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_conf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conf_q <= count_q)
    else $error("confident count above entry count");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> (rd_idx_q < count_q))
    else $error("read beyond the valid entries");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(p1_v_q || p2_v_q))
    else $error("write-back while compares still in flight");

  a_merge_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && m_found_q) |=> $stable(count_q))
    else $error("merge changed the entry count");

endmodule

// ===== rtl/core/detection_cluster_merge_table_unit.sv =====
// Top level of the detection cluster merge table: stream ports, controller and datapath.
//
//  channel  | direction | handshake                      | contents
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | detected pattern
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | merge result
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | min_hits threshold
//
// Each item is processed in turn: one read of the entry RAM per stored entry, two compare
// stages, and one write-back to the table.
// A result waits in an output register; the next item is accepted meanwhile, and its
// write-back stalls only while that earlier result has not been taken.
// Reset empties the table and clears the threshold; no clearing pass is needed.
// Configuration is taken in any cycle.
module detection_cluster_merge_table_unit
  import dcmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // x_coord, y_coord, pattern_size, initial_hits, then zero padding
  input  logic [((2*COORD_BITS+SIZE_W+HITS_W+7)/8)*8-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // merged, merged_index, dropped, entry_count, confident_count
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [HITS_W-1:0] cfg_wdata_i
);

  localparam int unsigned Y_LO = COORD_BITS;
  localparam int unsigned S_LO = 2 * COORD_BITS;
  localparam int unsigned H_LO = 2 * COORD_BITS + SIZE_W;

  dcmt_cmd_t         cmd;
  dcmt_status_t      status;
  logic              merged;
  logic [MIDX_W-1:0] merged_index;
  logic              dropped;
  logic [OCNT_W-1:0] entry_count;
  logic [OCNT_W-1:0] confident_count;

  assign cfg_ready_o = 1'b1;

  dcmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dcmt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .x_coord_i         (s_axis_tdata[COORD_BITS-1:0]),
    .y_coord_i         (s_axis_tdata[Y_LO +: COORD_BITS]),
    .pattern_size_i    (s_axis_tdata[S_LO +: SIZE_W]),
    .initial_hits_i    (s_axis_tdata[H_LO +: HITS_W]),
    .cfg_we_i          (cfg_valid_i),
    .cfg_min_hits_i    (cfg_wdata_i),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .merged_o          (merged),
    .merged_index_o    (merged_index),
    .dropped_o         (dropped),
    .entry_count_o     (entry_count),
    .confident_count_o (confident_count)
  );

  assign m_axis_tdata = {confident_count, entry_count, dropped, merged_index, merged};

endmodule

// ===== tb/sv/tb_detection_cluster_merge_table_unit.sv =====
// Self-checking stream testbench for the detection cluster merge table unit.
`timescale 1ns / 1ps

module tb_detection_cluster_merge_table_unit;
  import dcmt_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int unsigned CRD_W       = COORD_BITS_DEF;
  localparam int unsigned CRD_MAX     = (1 << CRD_W) - 1;
  localparam int unsigned SIZE_MAX    = (1 << SIZE_W) - 1;
  localparam int unsigned IN_W        = ((2*CRD_W + SIZE_W + HITS_W + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 80;

  typedef struct packed {
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [SIZE_W-1:0] size;
    logic [HITS_W-1:0] hits;
  } detection_t;

  typedef struct packed {
    logic              merged;
    logic [MIDX_W-1:0] index;
    logic              dropped;
    logic [OCNT_W-1:0] entries;
    logic [OCNT_W-1:0] confident;
  } merge_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [HITS_W-1:0] cfg_wdata_i   = '0;

  detection_cluster_merge_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the cluster table and threshold.
  logic [CRD_W-1:0]  cl_x    [DEPTH];
  logic [CRD_W-1:0]  cl_y    [DEPTH];
  logic [SIZE_W-1:0] cl_size [DEPTH];
  logic [HITS_W-1:0] cl_hits [DEPTH];
  int unsigned       cl_count = 0;
  logic [HITS_W-1:0] min_hits_shadow = '0;

  detection_t    detections_q[$];
  merge_result_t predicted_results[$];

  detection_t  offered;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  logic        hold_go   = 1'b0;
  logic        hold_done;
  logic        steady    = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (steady) begin
      return 0;
    end
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic int unsigned abs_delta(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned scaled_size(logic [SIZE_W-1:0] s);
    int unsigned v;
    v = s;
    return (v << 8) / 7;
  endfunction

  function automatic int unsigned clip(int v, int unsigned hi);
    if (v < 0) begin
      return 0;
    end
    if (v > int'(hi)) begin
      return hi;
    end
    return v;
  endfunction

  // Merges one detection into the shadow table and returns the result it must produce.
  function automatic merge_result_t predict_merge(detection_t d);
    merge_result_t r;
    int unsigned   in_ss, ts, k, conf, dx, dy;
    logic          hit;
    r     = '0;
    hit   = 1'b0;
    conf  = 0;
    dx    = d.x;
    dy    = d.y;
    in_ss = scaled_size(d.size);
    for (k = 0; k < cl_count; k++) begin
      ts = scaled_size(cl_size[k]);
      if (abs_delta(dx << 8, int'(cl_x[k]) << 8) < ts &&
          abs_delta(dy << 8, int'(cl_y[k]) << 8) < ts &&
          abs_delta(in_ss, ts) < (ts >> 2)) begin
        cl_x[k]    = CRD_W'((int'(cl_x[k]) + dx) >> 1);
        cl_y[k]    = CRD_W'((int'(cl_y[k]) + dy) >> 1);
        cl_size[k] = SIZE_W'((int'(cl_size[k]) + int'(d.size)) >> 1);
        if (cl_hits[k] != HITS_MAX) begin
          cl_hits[k] = cl_hits[k] + 1'b1;
        end
        hit     = 1'b1;
        r.index = MIDX_W'(k);
        break;
      end
    end
    r.merged = hit;
    if (!hit) begin
      if (cl_count < DEPTH) begin
        cl_x[cl_count]    = d.x;
        cl_y[cl_count]    = d.y;
        cl_size[cl_count] = d.size;
        cl_hits[cl_count] = d.hits;
        cl_count++;
      end else begin
        r.dropped = 1'b1;
      end
    end
    for (k = 0; k < cl_count; k++) begin
      if (cl_hits[k] > min_hits_shadow) begin
        conf++;
      end
    end
    r.entries   = OCNT_W'(cl_count);
    r.confident = OCNT_W'(conf);
    return r;
  endfunction

  function automatic detection_t random_detection();
    detection_t d;
    d.x    = CRD_W'($urandom());
    d.y    = CRD_W'($urandom());
    d.size = SIZE_W'($urandom());
    d.hits = HITS_W'($urandom());
    return d;
  endfunction

  // A detection close to a stored cluster, so that it usually merges.
  function automatic detection_t near_detection();
    detection_t  d;
    int unsigned k, sz, span;
    if (cl_count == 0) begin
      return random_detection();
    end
    k      = $urandom_range(cl_count - 1, 0);
    sz     = cl_size[k];
    span   = sz / 8;
    d.x    = CRD_W'(clip(int'(cl_x[k]) + int'($urandom_range(2*span, 0)) - int'(span),
                         CRD_MAX));
    d.y    = CRD_W'(clip(int'(cl_y[k]) + int'($urandom_range(2*span, 0)) - int'(span),
                         CRD_MAX));
    d.size = SIZE_W'(clip(int'(sz) + int'($urandom_range(2*span, 0)) - int'(span),
                          SIZE_MAX));
    d.hits = HITS_W'($urandom());
    return d;
  endfunction

  task automatic queue_detection(int unsigned x, int unsigned y, int unsigned s,
                                 int unsigned h);
    detection_t d;
    d.x    = CRD_W'(x);
    d.y    = CRD_W'(y);
    d.size = SIZE_W'(s);
    d.hits = HITS_W'(h);
    detections_q.insert(detections_q.size(), d);
  endtask

  // Returns once every queued item has been sent and every result has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (detections_q.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
  endtask

  task automatic write_min_hits(logic [HITS_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do begin
      @(posedge clk_i);
    end while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i     <= 1'b0;
    min_hits_shadow = value;
  endtask

  // Sender: offers the queued items, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predicted_results.insert(predicted_results.size(), predict_merge(offered));
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (detections_q.size() > 0) begin
        offered = detections_q.pop_front();
        s_axis_tdata  <= IN_W'({offered.hits, offered.size, offered.y, offered.x});
        s_axis_tvalid <= 1'b1;
        send_gap      = idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result and stalls at random, once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    merge_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.merged    = m_axis_tdata[0];
        got.index     = m_axis_tdata[4:1];
        got.dropped   = m_axis_tdata[5];
        got.entries   = m_axis_tdata[10:6];
        got.confident = m_axis_tdata[15:11];
        if (predicted_results.size() == 0) begin
          $error("result item with no detection outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (got.merged !== want.merged) begin
            $error("merged: expected %0d, got %0d", want.merged, got.merged);
            mismatches++;
          end
          if (got.index !== want.index) begin
            $error("merged_index: expected %0d, got %0d", want.index, got.index);
            mismatches++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
            mismatches++;
          end
          if (got.entries !== want.entries) begin
            $error("entry_count: expected %0d, got %0d", want.entries, got.entries);
            mismatches++;
          end
          if (got.confident !== want.confident) begin
            $error("confident_count: expected %0d, got %0d", want.confident, got.confident);
            mismatches++;
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    = idle_len();
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned fx[12], fy[12], fs[12];
    int unsigned k, ph;
    logic [HITS_W-1:0] level;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_min_hits('0);

    // Zero-size clusters never absorb anything, so the second one is appended.
    queue_detection(0, 0, 0, 0);
    queue_detection(0, 0, 0, 5);
    // Largest coordinates and size; merging keeps the hit count saturated.
    queue_detection(CRD_MAX, CRD_MAX, SIZE_MAX, HITS_MAX);
    queue_detection(CRD_MAX, CRD_MAX, SIZE_MAX, 0);
    queue_detection(4000, 4090, 900, 1);
    // One below saturation, then two merges that reach and hold the maximum.
    queue_detection(2048, 100, 70, HITS_MAX - 1);
    queue_detection(2049, 101, 70, 7);
    queue_detection(2047, 99, 72, 3);
    // Fill the table with well separated clusters.
    for (k = 0; k < 12; k++) begin
      fx[k] = 200 + (k % 4) * 1000;
      fy[k] = 300 + (k / 4) * 1000;
      fs[k] = $urandom_range(SIZE_MAX, 30);
      queue_detection(fx[k], fy[k], fs[k], $urandom());
    end
    // Table full: unmatched items are discarded, a match on the last entry still merges.
    queue_detection(10, 4000, 500, $urandom());
    queue_detection(CRD_MAX, 0, SIZE_MAX, 0);
    queue_detection(fx[11], fy[11], fs[11], HITS_MAX);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       level = HITS_MAX;
        1:       level = 1;
        2:       level = cl_hits[$urandom_range(cl_count - 1, 0)];
        3:       level = HITS_MAX - 1'b1;
        4:       level = HITS_W'($urandom());
        default: level = '0;
      endcase
      write_min_hits(level);
      steady  = (ph % 2) == 1;
      hold_go = hold_go || (ph == 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        while (detections_q.size() >= 2) begin
          @(posedge clk_i);
        end
        if ($urandom_range(99, 0) < 75) begin
          detections_q.insert(detections_q.size(), near_detection());
        end else begin
          detections_q.insert(detections_q.size(), random_detection());
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dcmt_pkg.sv
rtl/core/dcmt_ram.sv
rtl/core/dcmt_ctrl.sv
rtl/core/dcmt_dpath.sv
rtl/core/detection_cluster_merge_table_unit.sv
tb/sv/tb_detection_cluster_merge_table_unit.sv
